// File: rtl/sbsh_pkg.sv
package sbsh_pkg;

    localparam int WORD_W      = 32;
    localparam int BLOCK_WORDS = 16;
    localparam int WIN_AW      = $clog2(BLOCK_WORDS);
    localparam int ROUNDS      = 64;
    localparam int RND_W       = $clog2(ROUNDS);
    localparam int DIGEST_WORDS = 8;
    localparam int DIG_AW      = $clog2(DIGEST_WORDS);

    localparam logic [7:0]       PAD_MARK_BYTE = 8'h80;
    localparam logic [5:0]       FILL_LAST     = 6'd63;
    localparam logic [5:0]       FILL_LEN      = 6'd56;
    localparam logic [RND_W-1:0] RND_LAST      = RND_W'(ROUNDS - 1);
    localparam logic [DIG_AW-1:0] DIG_LAST     = DIG_AW'(DIGEST_WORDS - 1);

    localparam logic [WORD_W-1:0] INIT_HASH [DIGEST_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [WORD_W-1:0] ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } in_beat_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_number;
        logic        final_word;
    } out_beat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD_MARK,
        ST_PAD_ZERO,
        ST_PAD_LEN,
        ST_PREP,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } state_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned r);
        return (x >> r) | (x << (32 - r));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

// File: rtl/sha256_byte_stream_hasher.sv
// Channel  Direction  Payload     Beat
// s_       in         in_beat_t   one message byte, a finish mark, or both
// m_       out        out_beat_t  one digest word, eight per message
//
// A byte beat is taken only while idle; the beat that fills a 64-byte block is
// followed by a read setup step, 64 rounds of the shared round unit, a fold step.
// A finish pads one byte per cycle, pausing for each block compressed and once
// before the length field, then shows eight words, one per accepted beat.
// The message schedule window lives in a 16-word RAM with two read ports.
// Reset is synchronous on aresetn; m_ready may stall the digest words freely.
module sha256_byte_stream_hasher (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  sbsh_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output sbsh_pkg::out_beat_t m_data
);

    import sbsh_pkg::*;

    state_t               state_reg, state_next;
    state_t               ret_reg, ret_next;
    logic [5:0]           fill_reg;
    logic [63:0]          len_reg;
    logic [23:0]          word_reg;
    logic [RND_W-1:0]     rnd_reg;
    logic [DIG_AW-1:0]    emit_reg;
    logic [WORD_W-1:0]    chain_reg [DIGEST_WORDS];
    logic [WORD_W-1:0]    v_reg [DIGEST_WORDS];
    logic [WORD_W-1:0]    x16_reg, w1_reg, w2_reg;

    logic                 push_en;
    logic [7:0]           push_byte;
    logic [63:0]          len_bits;
    logic [5:0]           len_pos;

    logic                 ram_we;
    logic [WIN_AW-1:0]    ram_waddr, ram_raddr_a, ram_raddr_b;
    logic [WORD_W-1:0]    ram_wdata, rd_a, rd_b;
    logic [RND_W-1:0]     rd_round;

    logic                 early_round;
    logic [WORD_W-1:0]    w_cur, t1, t2, ch, maj;

    sbsh_ram #(
        .WIDTH (WORD_W),
        .DEPTH (BLOCK_WORDS)
    ) u_window (
        .aclk    (aclk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .raddr_b (ram_raddr_b),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    assign len_bits = {len_reg[60:0], 3'b000};
    assign len_pos  = {~fill_reg[2:0], 3'b000};

    always_comb begin
        push_en   = 1'b0;
        push_byte = '0;
        case (state_reg)
            ST_IDLE: begin
                push_en   = s_valid && s_data.byte_present;
                push_byte = s_data.data_byte;
            end
            ST_PAD_MARK: begin
                push_en   = 1'b1;
                push_byte = PAD_MARK_BYTE;
            end
            ST_PAD_ZERO: begin
                push_en   = (fill_reg != FILL_LEN);
            end
            ST_PAD_LEN: begin
                push_en   = 1'b1;
                push_byte = len_bits[len_pos +: 8];
            end
            default: begin
                push_en   = 1'b0;
            end
        endcase
    end

    assign early_round = (rnd_reg < RND_W'(BLOCK_WORDS));
    assign w_cur = early_round ? rd_b
                               : x16_reg + small_sigma0(rd_a) + rd_b + small_sigma1(w2_reg);
    assign ch    = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign maj   = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t1    = v_reg[7] + big_sigma1(v_reg[4]) + ch + ROUND_K[rnd_reg] + w_cur;
    assign t2    = big_sigma0(v_reg[0]) + maj;

    assign rd_round    = (state_reg == ST_ROUND) ? rnd_reg + 1'b1 : '0;
    assign ram_raddr_a = rd_round[WIN_AW-1:0] + 1'b1;
    assign ram_raddr_b = (rd_round < RND_W'(BLOCK_WORDS))
                       ? rd_round[WIN_AW-1:0]
                       : rd_round[WIN_AW-1:0] + WIN_AW'(9);

    always_comb begin
        if (push_en) begin
            ram_we    = (fill_reg[1:0] == 2'd3);
            ram_waddr = fill_reg[5:2];
            ram_wdata = {word_reg, push_byte};
        end else begin
            ram_we    = (state_reg == ST_ROUND) && !early_round;
            ram_waddr = rnd_reg[WIN_AW-1:0];
            ram_wdata = w_cur;
        end
    end

    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_data.byte_present && fill_reg == FILL_LAST) begin
                        state_next = ST_PREP;
                        ret_next   = s_data.end_of_message ? ST_PAD_MARK : ST_IDLE;
                    end else if (s_data.end_of_message) begin
                        state_next = ST_PAD_MARK;
                    end
                end
            end
            ST_PAD_MARK: begin
                state_next = ST_PAD_ZERO;
                if (fill_reg == FILL_LAST) begin
                    state_next = ST_PREP;
                    ret_next   = ST_PAD_ZERO;
                end
            end
            ST_PAD_ZERO: begin
                if (fill_reg == FILL_LEN) begin
                    state_next = ST_PAD_LEN;
                end else if (fill_reg == FILL_LAST) begin
                    state_next = ST_PREP;
                    ret_next   = ST_PAD_ZERO;
                end
            end
            ST_PAD_LEN: begin
                if (fill_reg == FILL_LAST) begin
                    state_next = ST_PREP;
                    ret_next   = ST_EMIT;
                end
            end
            ST_PREP: begin
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                if (rnd_reg == RND_LAST) begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD: begin
                state_next = ret_reg;
            end
            ST_EMIT: begin
                if (m_ready && emit_reg == DIG_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready             = (state_reg == ST_IDLE);
        m_valid             = (state_reg == ST_EMIT);
        m_data.digest_word  = chain_reg[emit_reg];
        m_data.word_number  = emit_reg;
        m_data.final_word   = (emit_reg == DIG_LAST);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            fill_reg  <= '0;
            len_reg   <= '0;
            rnd_reg   <= '0;
            emit_reg  <= '0;
            for (int i = 0; i < DIGEST_WORDS; i++) begin
                chain_reg[i] <= INIT_HASH[i];
            end
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            if (push_en) begin
                fill_reg <= fill_reg + 1'b1;
            end
            if (state_reg == ST_IDLE && s_valid && s_data.byte_present) begin
                len_reg <= len_reg + 1'b1;
            end
            case (state_reg)
                ST_PREP: begin
                    rnd_reg <= '0;
                end
                ST_ROUND: begin
                    rnd_reg <= rnd_reg + 1'b1;
                end
                ST_FOLD: begin
                    for (int i = 0; i < DIGEST_WORDS; i++) begin
                        chain_reg[i] <= chain_reg[i] + v_reg[i];
                    end
                end
                ST_EMIT: begin
                    if (m_ready) begin
                        emit_reg <= emit_reg + 1'b1;
                        if (emit_reg == DIG_LAST) begin
                            len_reg <= '0;
                            for (int i = 0; i < DIGEST_WORDS; i++) begin
                                chain_reg[i] <= INIT_HASH[i];
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (push_en) begin
            word_reg <= {word_reg[15:0], push_byte};
        end
        if (state_reg == ST_PREP) begin
            for (int i = 0; i < DIGEST_WORDS; i++) begin
                v_reg[i] <= chain_reg[i];
            end
        end
        if (state_reg == ST_ROUND) begin
            v_reg[0] <= t1 + t2;
            v_reg[1] <= v_reg[0];
            v_reg[2] <= v_reg[1];
            v_reg[3] <= v_reg[2];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[5] <= v_reg[4];
            v_reg[6] <= v_reg[5];
            v_reg[7] <= v_reg[6];
            x16_reg  <= rd_a;
            w2_reg   <= w1_reg;
            w1_reg   <= w_cur;
        end
    end

endmodule

// File: rtl/sbsh_ram.sv
module sbsh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// File: rtl/sbsh_checker.sv
module sbsh_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input sbsh_pkg::out_beat_t m_data
);

    import sbsh_pkg::*;

    // A stalled digest word holds its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("digest beat changed while stalled");

    // Input is never taken while a digest is being delivered.
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready during digest delivery");

    // The digest words come in order with no gap.
    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_data.final_word) |=>
        (m_valid && m_data.word_number == $past(m_data.word_number) + 3'd1))
        else $error("digest word out of order");

    // The final flag marks exactly the eighth word.
    a_final: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.final_word == (m_data.word_number == DIG_LAST)))
        else $error("final flag on wrong word");

    // After the last word the block drops valid and opens the input.
    a_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_data.final_word) |=> (!m_valid && s_ready))
        else $error("block did not return to idle after digest");

endmodule

bind sha256_byte_stream_hasher sbsh_checker u_sbsh_checker (.*);

// File: bench/sha256_byte_stream_hasher_check.sv
module sha256_byte_stream_hasher_check (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  sbsh_pkg::in_beat_t  s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  sbsh_pkg::out_beat_t m_data,
    output int                  mismatches,
    output int                  outstanding
);

    localparam logic [31:0] ROUND_CONST [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] START_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    logic [31:0]         chain [8];
    logic [7:0]          block_bytes [64];
    int                  fill;
    logic [63:0]         msg_bytes;
    sbsh_pkg::out_beat_t digest_q [$];
    int                  fail_count = 0;

    function automatic logic [31:0] rot_right(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_block();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h;
        logic [31:0] t1, t2, s0, s1;
        for (int t = 0; t < 16; t++) begin
            w[t] = {block_bytes[4*t], block_bytes[4*t+1], block_bytes[4*t+2],
                    block_bytes[4*t+3]};
        end
        for (int t = 16; t < 64; t++) begin
            s0 = rot_right(w[t-15], 7) ^ rot_right(w[t-15], 18) ^ (w[t-15] >> 3);
            s1 = rot_right(w[t-2], 17) ^ rot_right(w[t-2], 19) ^ (w[t-2] >> 10);
            w[t] = w[t-16] + s0 + w[t-7] + s1;
        end
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
        e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
        for (int t = 0; t < 64; t++) begin
            t1 = h + (rot_right(e, 6) ^ rot_right(e, 11) ^ rot_right(e, 25))
                 + ((e & f) ^ (~e & g)) + ROUND_CONST[t] + w[t];
            t2 = (rot_right(a, 2) ^ rot_right(a, 13) ^ rot_right(a, 22))
                 + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
        chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
    endtask

    task automatic take_byte(input logic [7:0] value);
        block_bytes[fill] = value;
        fill++;
        if (fill == 64) begin
            compress_block();
            fill = 0;
        end
    endtask

    // A finishing beat pads the message and queues the eight digest words.
    task automatic absorb_beat(input sbsh_pkg::in_beat_t beat);
        logic [63:0]         bit_len;
        sbsh_pkg::out_beat_t word;
        if (beat.byte_present) begin
            msg_bytes++;
            take_byte(beat.data_byte);
        end
        if (beat.end_of_message) begin
            bit_len = msg_bytes << 3;
            take_byte(8'h80);
            while (fill != 56) take_byte(8'h00);
            for (int i = 0; i < 8; i++) take_byte(bit_len[63-8*i -: 8]);
            for (int i = 0; i < 8; i++) begin
                word.digest_word = chain[i];
                word.word_number = 3'(i);
                word.final_word  = (i == 7);
                digest_q.insert(digest_q.size(), word);
            end
            chain     = START_HASH;
            fill      = 0;
            msg_bytes = '0;
        end
    endtask

    always @(posedge aclk) begin
        sbsh_pkg::out_beat_t want;
        if (!aresetn) begin
            chain     = START_HASH;
            fill      = 0;
            msg_bytes = '0;
            digest_q.delete();
        end else begin
            if (s_valid && s_ready) absorb_beat(s_data);
            if (m_valid && m_ready) begin
                if (digest_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("unexpected digest beat: word %h number %0d final %b",
                                 m_data.digest_word, m_data.word_number, m_data.final_word);
                    end
                end else begin
                    want = digest_q.pop_front();
                    if (m_data.digest_word !== want.digest_word ||
                        m_data.word_number !== want.word_number ||
                        m_data.final_word !== want.final_word) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("digest mismatch: expected %h/%0d/%b, got %h/%0d/%b",
                                     want.digest_word, want.word_number, want.final_word,
                                     m_data.digest_word, m_data.word_number,
                                     m_data.final_word);
                        end
                    end
                end
            end
        end
        mismatches  <= fail_count;
        outstanding <= digest_q.size();
    end

endmodule

// File: bench/sha256_byte_stream_hasher_test.sv
module sha256_byte_stream_hasher_test;

    import sbsh_pkg::*;

    localparam int ITEM_TARGET = 200;
    localparam int CYCLE_LIMIT = 400000;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    in_beat_t  s_data  = '0;
    logic      m_ready = 1'b0;
    logic      s_ready;
    logic      m_valid;
    out_beat_t m_data;

    int mismatches;
    int outstanding;
    int item_count = 0;
    int idle_pct   = 0;
    int rx_pct     = 0;
    int stall_left = 0;
    bit calm       = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    sha256_byte_stream_hasher u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    sha256_byte_stream_hasher_check u_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!calm && aresetn && $urandom_range(1, 100) <= rx_pct) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 14);
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic send_beat(input logic [7:0] value, input logic present,
                             input logic last);
        int gap;
        if (!calm && $urandom_range(1, 100) <= idle_pct) begin
            gap = $urandom_range(1, 15);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{data_byte: value, byte_present: present, end_of_message: last};
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_message(input int len, input bit bare);
        if (len == 0) bare = 1'b1;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 11) == 0) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_beat(8'($urandom_range(0, 255)), 1'b1, !bare && i == len - 1);
            item_count++;
        end
        if (bare) begin
            send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            item_count++;
        end
    endtask

    function automatic int pick_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 15;
            default: return 50;
        endcase
    endfunction

    initial begin
        for (int n = 0; n < CYCLE_LIMIT; n++) @(posedge aclk);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int len;
        int msg;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty message, "abc", idle beats, byte extremes, bare finish.
        send_beat(8'h5a, 1'b0, 1'b1);
        send_beat(8'h61, 1'b1, 1'b0);
        send_beat(8'h62, 1'b1, 1'b0);
        send_beat(8'h63, 1'b1, 1'b1);
        send_beat(8'hff, 1'b0, 1'b0);
        send_beat(8'h00, 1'b1, 1'b0);
        send_beat(8'ha5, 1'b0, 1'b0);
        send_beat(8'hff, 1'b1, 1'b0);
        send_beat(8'h80, 1'b1, 1'b0);
        send_beat(8'h7f, 1'b1, 1'b0);
        send_beat(8'h00, 1'b0, 1'b1);
        send_beat(8'hff, 1'b1, 1'b1);
        send_beat(8'h00, 1'b1, 1'b1);
        item_count = 11;

        // Lengths 55, 56 and 64 hit the one-block, two-block and full-block paddings.
        msg = 0;
        while (item_count < ITEM_TARGET) begin
            idle_pct = pick_pct();
            rx_pct   = pick_pct();
            if (item_count >= ITEM_TARGET * 4 / 5) calm = 1'b1;
            case (msg)
                1:       len = 55;
                3:       len = 56;
                5:       len = 64;
                default: len = $urandom_range(0, 20);
            endcase
            send_message(len, $urandom_range(0, 2) == 0);
            msg++;
        end

        calm = 1'b1;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/sbsh_pkg.sv
rtl/sbsh_ram.sv
rtl/sha256_byte_stream_hasher.sv
rtl/sbsh_checker.sv
bench/sha256_byte_stream_hasher_check.sv
bench/sha256_byte_stream_hasher_test.sv
